@@ hw/rtl/trm_pkg.sv @@
// shared types and constants of the transfer rate meter
package trm_pkg;

   localparam int unsigned TickW     = 32;
   localparam int unsigned ByteW     = 48;
   localparam int unsigned RateW     = 31;
   localparam int unsigned ProgW     = 17;
   localparam int unsigned IntervalW = 16;
   localparam int unsigned DvdW      = 64;
   localparam int unsigned DvsW      = 48;
   localparam int unsigned ProdW     = ByteW + 10;

   localparam int unsigned AvgDepthDefault = 4;
   localparam logic [IntervalW-1:0] IntervalReset = 16'd1000;
   localparam logic [ProgW-1:0] ProgFull = 17'h10000;
   localparam logic [RateW-1:0] RateMax  = 31'h7FFF_FFFF;
   localparam logic [TickW-1:0] TimeMax  = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PREP,
      ST_RATE_GO,
      ST_RATE_WT,
      ST_WRITE,
      ST_SPD_GO,
      ST_SPD_WT,
      ST_SPD_SET,
      ST_PRG_GO,
      ST_PRG_WT,
      ST_PRG_SET,
      ST_TIM_GO,
      ST_TIM_WT,
      ST_TIM_SET,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_RATE,
      DIV_SPEED,
      DIV_PROG,
      DIV_TIME
   } div_sel_type;

   typedef struct packed {
      logic        latch_req;
      logic        decide;
      logic        prep;
      logic        div_start;
      div_sel_type div_sel;
      logic        write_ring;
      logic        set_speed;
      logic        set_prog;
      logic        set_time;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sample_ok;
      logic total_zero;
      logic speed_zero;
      logic div_busy;
      logic rsp_free;
   } status_type;

endpackage

@@ hw/rtl/trm_div.sv @@
// shared restoring divider, one quotient bit per cycle
module trm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [trm_pkg::DvdW-1:0]   dividend,
   input  logic [trm_pkg::DvsW-1:0]   divisor,
   output logic                       busy,
   output logic [trm_pkg::DvdW-1:0]   quotient
);
   localparam int unsigned CntW = $clog2(trm_pkg::DvdW + 1);

   logic [trm_pkg::DvdW-1:0] dvd_ff, dvd_in;
   logic [trm_pkg::DvsW-1:0] dvs_ff, dvs_in;
   logic [trm_pkg::DvsW-1:0] rem_ff, rem_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [trm_pkg::DvsW:0]   trial;
   logic                     ge;

   // one shift and trial subtract per cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[trm_pkg::DvdW-1]};
      ge     = (trial >= {1'b0, dvs_ff});
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         cnt_in = CntW'(trm_pkg::DvdW);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? trm_pkg::DvsW'(trial - {1'b0, dvs_ff}) : trial[trm_pkg::DvsW-1:0];
         dvd_in = {dvd_ff[trm_pkg::DvdW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = dvd_ff;

endmodule

@@ hw/rtl/trm_ctrl.sv @@
// sequencer of the rate meter
module trm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  trm_pkg::status_type status,
   output trm_pkg::cmd_type    cmd
);
   trm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = trm_pkg::DIV_RATE;
      req_stall   = 1'b1;
      case (state_ff)
         trm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = trm_pkg::ST_DECIDE;
            end
         end
         trm_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = status.sample_ok ? trm_pkg::ST_PREP : trm_pkg::ST_DONE;
         end
         trm_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = trm_pkg::ST_RATE_GO;
         end
         trm_pkg::ST_RATE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = trm_pkg::DIV_RATE;
            state_in = trm_pkg::ST_RATE_WT;
         end
         trm_pkg::ST_RATE_WT: begin
            if (!status.div_busy) state_in = trm_pkg::ST_WRITE;
         end
         trm_pkg::ST_WRITE: begin
            cmd.write_ring = 1'b1;
            state_in = trm_pkg::ST_SPD_GO;
         end
         trm_pkg::ST_SPD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = trm_pkg::DIV_SPEED;
            state_in = trm_pkg::ST_SPD_WT;
         end
         trm_pkg::ST_SPD_WT: begin
            if (!status.div_busy) state_in = trm_pkg::ST_SPD_SET;
         end
         trm_pkg::ST_SPD_SET: begin
            cmd.set_speed = 1'b1;
            state_in = trm_pkg::ST_PRG_GO;
         end
         trm_pkg::ST_PRG_GO: begin
            // zero size needs no division
            if (status.total_zero) begin
               state_in = trm_pkg::ST_PRG_SET;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel = trm_pkg::DIV_PROG;
               state_in = trm_pkg::ST_PRG_WT;
            end
         end
         trm_pkg::ST_PRG_WT: begin
            if (!status.div_busy) state_in = trm_pkg::ST_PRG_SET;
         end
         trm_pkg::ST_PRG_SET: begin
            cmd.set_prog = 1'b1;
            state_in = trm_pkg::ST_TIM_GO;
         end
         trm_pkg::ST_TIM_GO: begin
            // zero speed saturates without division
            if (status.speed_zero) begin
               state_in = trm_pkg::ST_TIM_SET;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel = trm_pkg::DIV_TIME;
               state_in = trm_pkg::ST_TIM_WT;
            end
         end
         trm_pkg::ST_TIM_WT: begin
            if (!status.div_busy) state_in = trm_pkg::ST_TIM_SET;
         end
         trm_pkg::ST_TIM_SET: begin
            cmd.set_time = 1'b1;
            state_in = trm_pkg::ST_DONE;
         end
         trm_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = trm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = trm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/trm_dpath.sv @@
// registers, rate ring and arithmetic of the rate meter
module trm_dpath #(
   parameter int unsigned AVG_DEPTH = trm_pkg::AvgDepthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  trm_pkg::cmd_type                cmd,
   output trm_pkg::status_type             status,
   input  logic                            csr_valid,
   input  logic [trm_pkg::IntervalW-1:0]   csr_data,
   input  logic                            req_command,
   input  logic [trm_pkg::TickW-1:0]       req_now_ms,
   input  logic [trm_pkg::ByteW-1:0]       req_bytes_sent,
   input  logic [trm_pkg::ByteW-1:0]       req_total_size,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_updated,
   output logic [trm_pkg::RateW-1:0]       rsp_speed_bps,
   output logic [trm_pkg::ProgW-1:0]       rsp_progress_q16,
   output logic                            rsp_size_zero,
   output logic [trm_pkg::TickW-1:0]       rsp_time_left_s
);
   localparam int unsigned IdxW = $clog2(AVG_DEPTH);
   localparam int unsigned SumW = trm_pkg::RateW + IdxW;

   // ring mean as a multiply by the rounded-up reciprocal, 16 sum bits per cycle
   localparam int unsigned MeanShift = SumW + IdxW;
   localparam int unsigned MeanSteps = (SumW + 15) / 16;
   localparam int unsigned MeanPadW  = MeanSteps * 16;
   localparam int unsigned MeanProdW = 2 * SumW + 1;
   localparam int unsigned PartW     = SumW + 17;
   localparam int unsigned MeanCntW  = $clog2(MeanSteps + 1);
   localparam logic [63:0] MeanRecip = ((64'd1 << MeanShift) + 64'(AVG_DEPTH) - 64'd1)
                                       / 64'(AVG_DEPTH);
   localparam logic [SumW:0] MeanMul = MeanRecip[SumW:0];

   // configuration
   logic [trm_pkg::IntervalW-1:0] interval_ff;

   // latched request
   logic                         cmd_ff;
   logic [trm_pkg::TickW-1:0]    now_ff;
   logic [trm_pkg::ByteW-1:0]    bytes_ff;
   logic [trm_pkg::ByteW-1:0]    total_ff;

   // meter state
   logic [trm_pkg::TickW-1:0]    last_tick_ff;
   logic [trm_pkg::ByteW-1:0]    last_bytes_ff;
   logic [IdxW-1:0]              pos_ff;
   logic [SumW-1:0]              sum_ff;
   logic [AVG_DEPTH-1:0]         valid_ff;
   logic [trm_pkg::RateW-1:0]    ring_mem [AVG_DEPTH];
   logic [trm_pkg::RateW-1:0]    ring_q_ff;
   logic                         ring_qv_ff;
   logic [trm_pkg::RateW-1:0]    speed_ff;
   logic [trm_pkg::ProgW-1:0]    prog_ff;
   logic                         size_zero_ff;
   logic [trm_pkg::TickW-1:0]    time_ff;
   logic                         updated_ff;

   // working registers
   logic [trm_pkg::ByteW-1:0]    delta_ff;
   logic [trm_pkg::ProdW-1:0]    prod_ff;

   // ring mean unit
   logic [MeanPadW-1:0]          mean_sh_ff;
   logic [MeanProdW-1:0]         mean_acc_ff;
   logic [MeanCntW-1:0]          mean_cnt_ff;
   logic                         mean_start;
   logic                         mean_busy;
   logic [15:0]                  mean_digit;
   logic [PartW-1:0]             mean_part;

   // response registers
   logic                         rsp_valid_ff;
   logic                         rsp_upd_ff;
   logic [trm_pkg::RateW-1:0]    rsp_speed_ff;
   logic [trm_pkg::ProgW-1:0]    rsp_prog_ff;
   logic                         rsp_sz_ff;
   logic [trm_pkg::TickW-1:0]    rsp_time_ff;

   logic [trm_pkg::TickW-1:0]    dt;
   logic [trm_pkg::IntervalW-1:0] interval_eff;
   logic [trm_pkg::ByteW-1:0]    remaining;
   logic [trm_pkg::DvdW-1:0]     div_dvd;
   logic [trm_pkg::DvsW-1:0]     div_dvs;
   logic                         div_start;
   logic                         div_busy;
   logic [trm_pkg::DvdW-1:0]     div_q;
   logic [trm_pkg::RateW-1:0]    rate;
   logic [trm_pkg::RateW-1:0]    old_rate;
   logic [IdxW-1:0]              pos_next;

   // sample gate and operand selection
   always_comb begin
      interval_eff = (interval_ff == '0) ? trm_pkg::IntervalW'(1) : interval_ff;
      dt           = now_ff - last_tick_ff;
      remaining    = (total_ff > bytes_ff) ? (total_ff - bytes_ff) : '0;
      rate         = (div_q[trm_pkg::DvdW-1:trm_pkg::RateW] != '0) ? trm_pkg::RateMax
                                                          : div_q[trm_pkg::RateW-1:0];
      old_rate     = ring_qv_ff ? ring_q_ff : '0;
      pos_next     = (pos_ff == IdxW'(AVG_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      case (cmd.div_sel)
         trm_pkg::DIV_RATE: begin
            div_dvd = trm_pkg::DvdW'(prod_ff);
            div_dvs = trm_pkg::DvsW'(dt);
         end
         trm_pkg::DIV_PROG: begin
            div_dvd = {bytes_ff, 16'h0000};
            div_dvs = total_ff;
         end
         default: begin
            div_dvd = trm_pkg::DvdW'(remaining);
            div_dvs = trm_pkg::DvsW'(speed_ff);
         end
      endcase
   end

   // the ring mean goes to the mean unit, the rest to the divider
   assign mean_start = cmd.div_start && (cmd.div_sel == trm_pkg::DIV_SPEED);
   assign div_start  = cmd.div_start && (cmd.div_sel != trm_pkg::DIV_SPEED);

   trm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // one 16-bit slice of the sum times the reciprocal
   always_comb begin
      mean_digit = mean_sh_ff[MeanPadW-1 -: 16];
      mean_part  = PartW'(MeanMul) * PartW'(mean_digit);
   end

   // ring mean, most significant slice first
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_cnt_ff <= '0;
      end else if (mean_start) begin
         mean_cnt_ff <= MeanCntW'(MeanSteps);
      end else if (mean_cnt_ff != '0) begin
         mean_cnt_ff <= mean_cnt_ff - 1'b1;
      end
      if (mean_start) begin
         mean_sh_ff  <= MeanPadW'(sum_ff);
         mean_acc_ff <= '0;
      end else if (mean_cnt_ff != '0) begin
         mean_sh_ff  <= {mean_sh_ff[MeanPadW-17:0], 16'h0000};
         mean_acc_ff <= {mean_acc_ff[MeanProdW-17:0], 16'h0000} + MeanProdW'(mean_part);
      end
   end

   assign mean_busy = (mean_cnt_ff != '0);

   // ring memory
   always_ff @(posedge clock) begin
      if (cmd.write_ring) begin
         ring_mem[pos_ff] <= rate;
      end
      if (cmd.prep) begin
         ring_q_ff  <= ring_mem[pos_ff];
         ring_qv_ff <= valid_ff[pos_ff];
      end
   end

   // control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= trm_pkg::IntervalReset;
         last_tick_ff  <= '0;
         last_bytes_ff <= '0;
         pos_ff        <= '0;
         sum_ff        <= '0;
         valid_ff      <= '0;
         speed_ff      <= '0;
         prog_ff       <= '0;
         size_zero_ff  <= 1'b0;
         time_ff       <= '0;
         updated_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) interval_ff <= csr_data;
         if (cmd.decide) begin
            updated_ff <= 1'b0;
            if (cmd_ff) begin
               pos_ff   <= '0;
               sum_ff   <= '0;
               valid_ff <= '0;
            end
         end
         if (cmd.write_ring) begin
            valid_ff[pos_ff] <= 1'b1;
            sum_ff        <= sum_ff - SumW'(old_rate) + SumW'(rate);
            pos_ff        <= pos_next;
            last_tick_ff  <= now_ff;
            last_bytes_ff <= bytes_ff;
            updated_ff    <= 1'b1;
         end
         if (cmd.set_speed) speed_ff <= mean_acc_ff[MeanShift +: trm_pkg::RateW];
         if (cmd.set_prog) begin
            if (total_ff == '0) begin
               size_zero_ff <= 1'b1;
               prog_ff      <= trm_pkg::ProgFull;
            end else begin
               size_zero_ff <= 1'b0;
               prog_ff      <= (div_q > trm_pkg::DvdW'(trm_pkg::ProgFull)) ? trm_pkg::ProgFull
                                                              : div_q[trm_pkg::ProgW-1:0];
            end
         end
         if (cmd.set_time) begin
            if (speed_ff == '0 || div_q[trm_pkg::DvdW-1:trm_pkg::TickW] != '0) begin
               time_ff <= trm_pkg::TimeMax;
            end else begin
               time_ff <= div_q[trm_pkg::TickW-1:0];
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff   <= req_command;
         now_ff   <= req_now_ms;
         bytes_ff <= req_bytes_sent;
         total_ff <= req_total_size;
      end
      if (cmd.decide) begin
         delta_ff <= (bytes_ff > last_bytes_ff) ? (bytes_ff - last_bytes_ff)
                                                : (last_bytes_ff - bytes_ff);
      end
      // times 1000 as 1024 - 16 - 8
      if (cmd.prep) begin
         prod_ff <= {delta_ff, 10'b0} - trm_pkg::ProdW'({delta_ff, 4'b0})
                                      - trm_pkg::ProdW'({delta_ff, 3'b0});
      end
      if (cmd.load_rsp) begin
         rsp_upd_ff   <= updated_ff;
         rsp_speed_ff <= speed_ff;
         rsp_prog_ff  <= prog_ff;
         rsp_sz_ff    <= size_zero_ff;
         rsp_time_ff  <= time_ff;
      end
   end

   assign status.sample_ok  = !cmd_ff && (dt >= trm_pkg::TickW'(interval_eff));
   assign status.total_zero = (total_ff == '0);
   assign status.speed_zero = (speed_ff == '0);
   assign status.div_busy   = div_busy || mean_busy;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_updated      = rsp_upd_ff;
   assign rsp_speed_bps    = rsp_speed_ff;
   assign rsp_progress_q16 = rsp_prog_ff;
   assign rsp_size_zero    = rsp_sz_ff;
   assign rsp_time_left_s  = rsp_time_ff;

endmodule

@@ hw/rtl/transfer_rate_meter.sv @@
// top level of the transfer rate meter
//
// Throughput meter for a running transfer. Each request carries a command
// (sample or clear history), a millisecond timestamp, bytes sent so far and
// the total size. Every request yields exactly one response that reports the
// held speed, progress, size-zero flag and seconds left, plus whether this
// request was an accepted sample.
// A clear or a rejected sample goes from the decide state straight to the response.
// An accepted sample runs three 64-step divisions on one shared restoring
// divider (rate, progress, time left) and a 3-step ring mean; a zero size
// or a zero speed skips its division.
// One request is in work at a time; the next is accepted the cycle after
// the response is loaded, so the divider sets the throughput.
// The csr channel writes the update interval and is always ready; write it
// only while the meter is idle.
// Reset (synchronous) sets the interval to 1000 ms and clears history and
// held values. While the receiver stalls, the response register holds its
// value and a finished request waits; no new request is taken in meanwhile.
module transfer_rate_meter #(
   parameter int unsigned AVG_DEPTH = trm_pkg::AvgDepthDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [trm_pkg::IntervalW-1:0]   csr_update_interval_ms,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [trm_pkg::TickW-1:0]       req_now_ms,
   input  logic [trm_pkg::ByteW-1:0]       req_bytes_sent,
   input  logic [trm_pkg::ByteW-1:0]       req_total_size,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_updated,
   output logic [trm_pkg::RateW-1:0]       rsp_speed_bps,
   output logic [trm_pkg::ProgW-1:0]       rsp_progress_q16,
   output logic                            rsp_size_zero,
   output logic [trm_pkg::TickW-1:0]       rsp_time_left_s
);
   trm_pkg::cmd_type    cmd;
   trm_pkg::status_type status;

   assign csr_ready = 1'b1;

   trm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trm_dpath #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_data         (csr_update_interval_ms),
      .req_command      (req_command),
      .req_now_ms       (req_now_ms),
      .req_bytes_sent   (req_bytes_sent),
      .req_total_size   (req_total_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_updated      (rsp_updated),
      .rsp_speed_bps    (rsp_speed_bps),
      .rsp_progress_q16 (rsp_progress_q16),
      .rsp_size_zero    (rsp_size_zero),
      .rsp_time_left_s  (rsp_time_left_s)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// testbench of the transfer rate meter: random and directed requests checked by a predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RingDepth = trm_pkg::AvgDepthDefault;
   localparam int unsigned IdleLimit = 20000;

   typedef struct packed {
      logic                      command;
      logic [trm_pkg::TickW-1:0] now_ms;
      logic [trm_pkg::ByteW-1:0] bytes_sent;
      logic [trm_pkg::ByteW-1:0] total_size;
   } meter_req_type;

   typedef struct packed {
      logic                      updated;
      logic [trm_pkg::RateW-1:0] speed_bps;
      logic [trm_pkg::ProgW-1:0] progress_q16;
      logic                      size_zero;
      logic [trm_pkg::TickW-1:0] time_left_s;
   } meter_rsp_type;

   localparam logic CmdSample = 1'b0;
   localparam logic CmdClear  = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [trm_pkg::IntervalW-1:0] csr_update_interval_ms = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = 1'b0;
   logic [trm_pkg::TickW-1:0] req_now_ms = '0;
   logic [trm_pkg::ByteW-1:0] req_bytes_sent = '0;
   logic [trm_pkg::ByteW-1:0] req_total_size = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_updated;
   logic [trm_pkg::RateW-1:0] rsp_speed_bps;
   logic [trm_pkg::ProgW-1:0] rsp_progress_q16;
   logic rsp_size_zero;
   logic [trm_pkg::TickW-1:0] rsp_time_left_s;

   transfer_rate_meter dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [trm_pkg::IntervalW-1:0] interval_reg = trm_pkg::IntervalReset;
   logic [trm_pkg::TickW-1:0] last_tick = '0;
   logic [trm_pkg::ByteW-1:0] last_bytes = '0;
   logic [trm_pkg::RateW-1:0] rate_ring [RingDepth];
   int unsigned ring_pos = 0;
   meter_rsp_type held = '0;

   meter_req_type pending_reqs [$];
   meter_rsp_type expected_rsps [$];
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_off_cycles = 0;
   bit ring_init_done = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      fail_count++;
   endtask

   // compute the response of one request and advance the predictor state
   function automatic meter_rsp_type predict_meter(input meter_req_type r);
      logic [trm_pkg::TickW-1:0] dt;
      logic [31:0] limit;
      logic [trm_pkg::ByteW-1:0] delta;
      logic [63:0] rate;
      logic [63:0] sum;
      logic [63:0] quo;
      logic [trm_pkg::ByteW-1:0] remaining;
      meter_rsp_type o;
      o = held;
      o.updated = 1'b0;
      if (r.command == CmdClear) begin
         foreach (rate_ring[i]) rate_ring[i] = '0;
         ring_pos = 0;
      end else begin
         dt = r.now_ms - last_tick;
         limit = (interval_reg == 0) ? 32'd1 : {16'd0, interval_reg};
         if (dt >= limit) begin
            delta = (r.bytes_sent > last_bytes) ? r.bytes_sent - last_bytes
                                                : last_bytes - r.bytes_sent;
            rate = (64'(delta) * 64'd1000) / 64'(dt);
            if (rate > 64'(trm_pkg::RateMax)) rate = 64'(trm_pkg::RateMax);
            rate_ring[ring_pos] = rate[trm_pkg::RateW-1:0];
            ring_pos = (ring_pos + 1) % RingDepth;
            sum = 0;
            foreach (rate_ring[i]) sum += rate_ring[i];
            held.speed_bps = trm_pkg::RateW'(sum / RingDepth);
            if (r.total_size == 0) begin
               held.size_zero = 1'b1;
               held.progress_q16 = trm_pkg::ProgFull;
            end else begin
               held.size_zero = 1'b0;
               quo = {r.bytes_sent, 16'd0} / 64'(r.total_size);
               held.progress_q16 = (quo > 64'h10000) ? trm_pkg::ProgFull
                                                     : quo[trm_pkg::ProgW-1:0];
            end
            remaining = (r.total_size > r.bytes_sent) ? r.total_size - r.bytes_sent : '0;
            if (held.speed_bps == 0) begin
               held.time_left_s = trm_pkg::TimeMax;
            end else begin
               quo = 64'(remaining) / 64'(held.speed_bps);
               held.time_left_s = (quo > 64'(trm_pkg::TimeMax)) ? trm_pkg::TimeMax
                                                                : quo[trm_pkg::TickW-1:0];
            end
            last_tick = r.now_ms;
            last_bytes = r.bytes_sent;
            o = held;
            o.updated = 1'b1;
         end
      end
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            meter_req_type r;
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_command <= r.command;
            req_now_ms <= r.now_ms;
            req_bytes_sent <= r.bytes_sent;
            req_total_size <= r.total_size;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_off_cycles != 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      meter_rsp_type want;
      if (!ring_init_done) begin
         foreach (rate_ring[i]) rate_ring[i] = '0;
         ring_init_done = 1;
      end
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_meter({req_command, req_now_ms,
                                                   req_bytes_sent, req_total_size}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_updated !== want.updated)
                  report_mismatch("updated", rsp_updated, want.updated);
               if (rsp_speed_bps !== want.speed_bps)
                  report_mismatch("speed_bps", rsp_speed_bps, want.speed_bps);
               if (rsp_progress_q16 !== want.progress_q16)
                  report_mismatch("progress_q16", rsp_progress_q16, want.progress_q16);
               if (rsp_size_zero !== want.size_zero)
                  report_mismatch("size_zero", rsp_size_zero, want.size_zero);
               if (rsp_time_left_s !== want.time_left_s)
                  report_mismatch("time_left_s", rsp_time_left_s, want.time_left_s);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (quiet_cycles >= IdleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [trm_pkg::ByteW-1:0] rand_bytes();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // append a request to the driver queue
   task automatic add_req(input logic cmd, input logic [trm_pkg::TickW-1:0] now,
                          input logic [trm_pkg::ByteW-1:0] sent,
                          input logic [trm_pkg::ByteW-1:0] total);
      meter_req_type r;
      r.command = cmd;
      r.now_ms = now;
      r.bytes_sent = sent;
      r.total_size = total;
      pending_reqs.push_back(r);
   endtask

   // wait until the queue drains and every response has come back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (300) @(posedge clock);
   endtask

   // write the update interval while the meter is idle
   task automatic write_interval(input logic [trm_pkg::IntervalW-1:0] value);
      csr_valid <= 1'b1;
      csr_update_interval_ms <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      interval_reg = value;
   endtask

   // random transfer: mostly well-formed progressions with occasional noise
   task automatic random_phase(input int unsigned count,
                               input logic [trm_pkg::IntervalW-1:0] ivl);
      logic [trm_pkg::TickW-1:0] now;
      logic [trm_pkg::ByteW-1:0] sent;
      logic [trm_pkg::ByteW-1:0] total;
      int unsigned k;
      now = last_tick;
      sent = '0;
      total = rand_bytes();
      for (k = 0; k < count; k++) begin
         case ($urandom_range(19))
            0: add_req(CmdClear, $urandom, rand_bytes(), rand_bytes());
            1: add_req(CmdSample, $urandom, rand_bytes(), rand_bytes());
            2: begin
               total = ($urandom_range(3) == 0) ? '0 : rand_bytes();
               sent = '0;
               add_req(CmdSample, now, sent, total);
            end
            default: begin
               now = now + ivl + $urandom_range(ivl) - ($urandom_range(3) == 0 ? ivl / 2 : 0);
               sent = sent + ($urandom_range(1) ? 48'($urandom_range(100000))
                                                 : {16'($urandom_range(3)), 32'($urandom)});
               add_req(CmdSample, now, sent, total);
            end
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset interval, extremes, clear, zero size, overrun, overflow
      add_req(CmdSample, 32'd500, 48'd100, 48'd1000);
      add_req(CmdSample, 32'd1000, 48'd500, 48'd1000);
      add_req(CmdSample, 32'd2000, 48'd1500, 48'd1000);
      add_req(CmdSample, 32'd3000, 48'd1500, 48'd0);
      add_req(CmdClear, 32'hFFFF_FFFF, '1, '1);
      add_req(CmdSample, 32'd4000, 48'd1500, 48'd1000000);
      add_req(CmdSample, 32'd5000, '1, '1);
      add_req(CmdSample, 32'd6000, '0, '1);
      add_req(CmdSample, 32'hFFFF_FFF0, 48'd10, 48'hFFFF_FFFF_FFFF);
      add_req(CmdSample, 32'd1000, 48'd11, 48'hFFFF_FFFF_FFFF);
      add_req(CmdClear, '0, '0, '0);
      add_req(CmdSample, 32'd3000, 48'h8000_0000_0000, 48'h8000_0000_0001);
      drain();

      // zero interval behaves as one
      write_interval('0);
      add_req(CmdSample, last_tick, 48'd5, 48'd5);
      add_req(CmdSample, last_tick + 1, 48'd0, 48'd7);
      add_req(CmdSample, last_tick + 2, '1, 48'd1);
      drain();

      // receiver idles more than sender, long hold-off to fill the block
      write_interval(16'd1);
      send_idle_pct = 22;
      recv_idle_pct = 46;
      hold_off_cycles = 2000;
      random_phase(600, 16'd1);
      drain();

      write_interval(16'hFFFF);
      send_idle_pct = 46;
      recv_idle_pct = 22;
      random_phase(550, 16'hFFFF);
      drain();

      write_interval(16'd250);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(600, 16'd250);
      drain();

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
